[rtl/bpa_pkg.sv]
// Package for the buddy page allocator: codes, widths, controller states,
// datapath commands and the datapath status bundle. No dependencies.
package bpa_pkg;

    localparam int NUM_PAGES_DEF = 4096;
    localparam int ORDERS_DEF    = 11;

    // fixed port widths
    localparam int MODE_W   = 2;
    localparam int ORDER_W  = 4;
    localparam int PAGE_W   = 12;
    localparam int LIMIT_W  = 13;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 13;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 13'd4096;

    localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ORDER = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_PAGE  = 2'd3;

    localparam logic [1:0] KIND_UNUSED = 2'd0;
    localparam logic [1:0] KIND_FREE   = 2'd1;
    localparam logic [1:0] KIND_HEAD   = 2'd2;
    localparam logic [1:0] KIND_ELEM   = 2'd3;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CARVE_SIZE, S_SCAN_RD, S_SCAN_CHK, S_FILL_FREE,
        S_PUSH1, S_PUSH2, S_CARVE_NEXT, S_SEARCH, S_UNLINK_RD, S_UNLINK_A,
        S_UNLINK_B, S_ALLOC_SET, S_FILL_ALLOC, S_SPLIT, S_REL_RD, S_REL_CHK,
        S_MERGE_RD, S_MERGE_TEST, S_MERGE_STEP, S_REL_SET, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_LOAD_ADD, OP_LOAD_ALLOC, OP_LOAD_REL, OP_LOAD_NOP,
        OP_CARVE_SIZE, OP_SCAN_RD, OP_SCAN_CHK, OP_FILL_FREE, OP_FILL_ALLOC,
        OP_PUSH1, OP_PUSH2, OP_CARVE_NEXT, OP_SEARCH, OP_UNLINK_RD, OP_UNLINK_A,
        OP_UNLINK_B, OP_ALLOC_SET, OP_SPLIT, OP_REL_RD, OP_REL_CHK, OP_MERGE_RD,
        OP_MERGE_STEP, OP_REL_SET
    } t_dp_op;

    typedef struct packed {
        logic range_ok;
        logic req_bad;
        logic first_bad;
        logic clr_last;
        logic kind_unused;
        logic kind_head;
        logic cnt_last;
        logic head_ok;
        logic ord_last;
        logic split_need;
        logic carve_end;
        logic can_merge;
        logic buddy_free;
    } t_dp_stat;

endpackage

[rtl/bpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/bpa_datapath.sv]
// Datapath of the buddy page allocator: per-page info, link memories, list
// heads, free count and result registers. Uses bpa_pkg and bpa_ram.
module bpa_datapath import bpa_pkg::*; #(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int ORDERS    = ORDERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_op              i_op,
    input  logic [ORDER_W-1:0]  i_order,
    input  logic [PAGE_W-1:0]   i_first_page,
    input  logic [PAGE_W-1:0]   i_last_page,
    input  logic                i_cfg_we,
    input  logic [LIMIT_W-1:0]  i_cfg_wdata,
    output t_dp_stat            o_stat,
    output logic [STATUS_W-1:0] o_status,
    output logic [PAGE_W-1:0]   o_page,
    output logic [ORDER_W-1:0]  o_block_order,
    output logic [TOTAL_W-1:0]  o_free_total
);
    localparam int PAW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int LW  = PAW + 1;
    localparam int OB  = $clog2(ORDERS);
    localparam int IW  = 2 + OB;
    localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);

    logic [LIMIT_W-1:0] r_limit;
    logic [LW-1:0]      r_cur, r_end, r_cnt, r_free;
    logic [PAW-1:0]     r_blk, r_bud, r_page, r_clr;
    logic [OB-1:0]      r_ord, r_ford, r_req, r_bord;
    logic [STATUS_W-1:0] r_status;
    logic [LW-1:0]      r_heads [ORDERS];

    // memory ports
    logic           w_info_we, w_info_re, w_link_re;
    logic [PAW-1:0] w_info_waddr, w_info_raddr;
    logic [IW-1:0]  w_info_wdata, w_info;
    logic           w_next_we, w_prev_we;
    logic [PAW-1:0] w_next_waddr, w_prev_waddr;
    logic [LW-1:0]  w_next_wdata, w_prev_wdata, w_nxt, w_prv;

    logic [1:0]     w_kind;
    logic [OB-1:0]  w_iord, w_co;
    logic [LW-1:0]  w_size, w_rem, w_cur_next, w_head_cur, w_head_f;
    logic [PAW-1:0] w_bud, w_addr_cnt;
    logic [31:0]    w_last_clip;

    assign w_kind     = w_info[IW-1:OB];
    assign w_iord     = w_info[OB-1:0];
    assign w_size     = LW'(1) << r_ford;
    assign w_rem      = r_end - r_cur + LW'(1);
    assign w_cur_next = r_cur + w_size;
    assign w_head_cur = r_heads[r_ord];
    assign w_head_f   = r_heads[r_ford];
    assign w_bud      = r_blk ^ (PAW'(1) << r_ord);
    assign w_addr_cnt = PAW'(LW'(r_blk) + r_cnt);
    assign w_last_clip = (32'(i_last_page) > NUM_PAGES - 1) ? 32'(NUM_PAGES - 1)
                                                            : 32'(i_last_page);

    // block order for carving: trailing zeros of the start capped, then
    // shrunk to the largest power of two within the remaining range
    always_comb begin
        int tz;
        int ms;
        tz = ORDERS - 1;
        for (int k = ORDERS - 2; k >= 0; k--) begin
            if (k < LW && r_cur[k % LW]) begin
                tz = k;
            end
        end
        ms = 0;
        for (int k = 0; k < LW; k++) begin
            if (w_rem[k]) begin
                ms = k;
            end
        end
        w_co = (ms < tz) ? OB'(ms) : OB'(tz);
    end

    always_comb begin
        o_stat.range_ok    = 32'(i_first_page) <= w_last_clip;
        o_stat.req_bad     = 32'(i_order) >= ORDERS;
        o_stat.first_bad   = 32'(i_first_page) >= NUM_PAGES;
        o_stat.clr_last    = r_clr == PAW'(NUM_PAGES - 1);
        o_stat.kind_unused = w_kind == KIND_UNUSED;
        o_stat.kind_head   = w_kind == KIND_HEAD;
        o_stat.cnt_last    = r_cnt == w_size - LW'(1);
        o_stat.head_ok     = w_head_cur < NIL;
        o_stat.ord_last    = r_ord == OB'(ORDERS - 1);
        o_stat.split_need  = r_ord > r_req;
        o_stat.carve_end   = w_cur_next > r_end;
        o_stat.can_merge   = (32'(r_ord) + 1 < ORDERS) && (32'(w_bud) < 32'(r_limit))
                             && (32'(w_bud) < NUM_PAGES);
        o_stat.buddy_free  = (w_kind == KIND_FREE) && (w_iord == r_ord);
    end

    // memory control
    always_comb begin
        w_info_we    = 1'b0;
        w_info_waddr = w_addr_cnt;
        w_info_wdata = {KIND_FREE, r_ford};
        w_info_re    = 1'b0;
        w_info_raddr = w_addr_cnt;
        w_link_re    = 1'b0;
        w_next_we    = 1'b0;
        w_next_waddr = r_blk;
        w_next_wdata = w_head_f;
        w_prev_we    = 1'b0;
        w_prev_waddr = r_blk;
        w_prev_wdata = NIL;
        case (i_op)
            OP_CLEAR: begin
                w_info_we    = 1'b1;
                w_info_waddr = r_clr;
                w_info_wdata = {KIND_UNUSED, OB'(0)};
            end
            OP_SCAN_RD: w_info_re = 1'b1;
            OP_FILL_FREE: w_info_we = 1'b1;
            OP_FILL_ALLOC: begin
                w_info_we    = 1'b1;
                w_info_wdata = {(r_cnt == '0) ? KIND_HEAD : KIND_ELEM, r_ford};
            end
            OP_PUSH1: begin
                w_next_we = 1'b1;
                w_prev_we = 1'b1;
            end
            OP_PUSH2: begin
                w_prev_we    = w_head_f < NIL;
                w_prev_waddr = PAW'(w_head_f);
                w_prev_wdata = LW'(r_blk);
            end
            OP_UNLINK_RD: w_link_re = 1'b1;
            OP_UNLINK_A: begin
                w_next_we    = w_prv < NIL;
                w_next_waddr = PAW'(w_prv);
                w_next_wdata = w_nxt;
            end
            OP_UNLINK_B: begin
                w_prev_we    = w_nxt < NIL;
                w_prev_waddr = PAW'(w_nxt);
                w_prev_wdata = w_prv;
            end
            OP_REL_RD: begin
                w_info_re    = 1'b1;
                w_info_raddr = r_blk;
            end
            OP_MERGE_RD: begin
                w_info_re    = 1'b1;
                w_info_raddr = w_bud;
            end
            default: ;
        endcase
    end

    bpa_ram #(.WIDTH(IW), .DEPTH(NUM_PAGES)) u_info (
        .i_clk(i_clk), .i_we(w_info_we), .i_waddr(w_info_waddr), .i_wdata(w_info_wdata),
        .i_re(w_info_re), .i_raddr(w_info_raddr), .o_rdata(w_info)
    );
    bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_next (
        .i_clk(i_clk), .i_we(w_next_we), .i_waddr(w_next_waddr), .i_wdata(w_next_wdata),
        .i_re(w_link_re), .i_raddr(r_bud), .o_rdata(w_nxt)
    );
    bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_prev (
        .i_clk(i_clk), .i_we(w_prev_we), .i_waddr(w_prev_waddr), .i_wdata(w_prev_wdata),
        .i_re(w_link_re), .i_raddr(r_bud), .o_rdata(w_prv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RST;
            r_free   <= '0;
            r_clr    <= '0;
            r_status <= ST_OK;
            r_page   <= '0;
            r_bord   <= '0;
            r_cnt    <= '0;
            for (int i = 0; i < ORDERS; i++) begin
                r_heads[i] <= NIL;
            end
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            case (i_op)
                OP_CLEAR: r_clr <= r_clr + PAW'(1);
                OP_LOAD_ADD, OP_LOAD_ALLOC, OP_LOAD_REL, OP_LOAD_NOP: begin
                    r_status <= ST_OK;
                    r_page   <= '0;
                    r_bord   <= '0;
                    r_cnt    <= '0;
                    r_cur    <= LW'(i_first_page);
                    r_end    <= LW'(w_last_clip);
                    r_blk    <= PAW'(i_first_page);
                    r_ord    <= OB'(i_order);
                    r_req    <= OB'(i_order);
                    if (i_op == OP_LOAD_ALLOC && o_stat.req_bad) begin
                        r_status <= ST_BAD_ORDER;
                    end
                    if (i_op == OP_LOAD_REL && o_stat.first_bad) begin
                        r_status <= ST_BAD_PAGE;
                    end
                end
                OP_CARVE_SIZE: begin
                    r_ford <= w_co;
                    r_blk  <= PAW'(r_cur);
                    r_cnt  <= '0;
                end
                OP_SCAN_CHK: begin
                    r_cnt <= (o_stat.cnt_last || !o_stat.kind_unused) ? '0 : r_cnt + LW'(1);
                end
                OP_FILL_FREE, OP_FILL_ALLOC: begin
                    r_cnt <= o_stat.cnt_last ? '0 : r_cnt + LW'(1);
                end
                OP_PUSH2: begin
                    r_heads[r_ford] <= LW'(r_blk);
                    r_free          <= r_free + w_size;
                end
                OP_CARVE_NEXT: r_cur <= w_cur_next;
                OP_SEARCH: begin
                    if (o_stat.head_ok) begin
                        r_bud <= PAW'(w_head_cur);
                    end else if (o_stat.ord_last) begin
                        r_status <= ST_NO_BLOCK;
                    end else begin
                        r_ord <= r_ord + OB'(1);
                    end
                end
                OP_UNLINK_A: begin
                    if (!(w_prv < NIL)) begin
                        r_heads[r_ord] <= w_nxt;
                    end
                    r_free <= r_free - (LW'(1) << r_ord);
                end
                OP_ALLOC_SET: begin
                    r_blk  <= r_bud;
                    r_ford <= r_req;
                    r_cnt  <= '0;
                    r_page <= r_bud;
                    r_bord <= r_req;
                end
                OP_SPLIT: begin
                    r_cur <= LW'(r_blk) + (LW'(1) << r_req);
                    r_end <= LW'(r_blk) + (LW'(1) << r_ord) - LW'(1);
                end
                OP_REL_CHK: begin
                    r_ord <= w_iord;
                    if (!o_stat.kind_head) begin
                        r_status <= ST_BAD_PAGE;
                    end
                end
                OP_MERGE_RD: r_bud <= w_bud;
                OP_MERGE_STEP: begin
                    if (r_bud < r_blk) begin
                        r_blk <= r_bud;
                    end
                    r_ord <= r_ord + OB'(1);
                end
                OP_REL_SET: begin
                    r_ford <= r_ord;
                    r_cnt  <= '0;
                    r_page <= r_blk;
                    r_bord <= r_ord;
                end
                default: ;
            endcase
        end
    end

    assign o_status      = r_status;
    assign o_page        = PAGE_W'(r_page);
    assign o_block_order = ORDER_W'(r_bord);
    assign o_free_total  = TOTAL_W'(r_free);

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= NIL)
        else $error("free count beyond page count");
    a_unlink_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_UNLINK_A && !(w_prv < NIL)) |-> w_head_cur == LW'(r_bud))
        else $error("unlinked block without predecessor is not list head");
    a_alloc_fill_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == OP_FILL_ALLOC |-> r_status == ST_OK)
        else $error("allocation fill after a failed request");
endmodule

[rtl/bpa_ctrl.sv]
// Controller state machine of the buddy page allocator: sequences the
// datapath commands per transaction. Uses bpa_pkg.
module bpa_ctrl import bpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MODE_W-1:0] i_mode,
    input  t_dp_stat          i_stat,
    output t_dp_op            o_op,
    output logic              o_busy,
    output logic              o_done
);
    t_state             r_state, n_state;
    logic [MODE_W-1:0]  r_mode, n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mode  <= MODE_ADD;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        o_op    = OP_NONE;
        case (r_state)
            S_CLEAR: begin
                o_op = OP_CLEAR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_mode = i_mode;
                    case (i_mode)
                        MODE_ADD: begin
                            o_op    = OP_LOAD_ADD;
                            n_state = i_stat.range_ok ? S_CARVE_SIZE : S_DONE;
                        end
                        MODE_ALLOC: begin
                            o_op    = OP_LOAD_ALLOC;
                            n_state = i_stat.req_bad ? S_DONE : S_SEARCH;
                        end
                        MODE_RELEASE: begin
                            o_op    = OP_LOAD_REL;
                            n_state = i_stat.first_bad ? S_DONE : S_REL_RD;
                        end
                        default: begin
                            o_op    = OP_LOAD_NOP;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CARVE_SIZE: begin
                o_op    = OP_CARVE_SIZE;
                n_state = (r_mode == MODE_ADD) ? S_SCAN_RD : S_FILL_FREE;
            end
            S_SCAN_RD: begin
                o_op    = OP_SCAN_RD;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_op = OP_SCAN_CHK;
                if (!i_stat.kind_unused) n_state = S_CARVE_NEXT;  // block skipped whole
                else if (i_stat.cnt_last) n_state = S_FILL_FREE;
                else n_state = S_SCAN_RD;
            end
            S_FILL_FREE: begin
                o_op = OP_FILL_FREE;
                if (i_stat.cnt_last) n_state = S_PUSH1;
            end
            S_PUSH1: begin
                o_op    = OP_PUSH1;
                n_state = S_PUSH2;
            end
            S_PUSH2: begin
                o_op    = OP_PUSH2;
                n_state = (r_mode == MODE_RELEASE) ? S_DONE : S_CARVE_NEXT;
            end
            S_CARVE_NEXT: begin
                o_op    = OP_CARVE_NEXT;
                n_state = i_stat.carve_end ? S_DONE : S_CARVE_SIZE;
            end
            S_SEARCH: begin
                o_op = OP_SEARCH;
                if (i_stat.head_ok) n_state = S_UNLINK_RD;
                else if (i_stat.ord_last) n_state = S_DONE;
            end
            S_UNLINK_RD: begin
                o_op    = OP_UNLINK_RD;
                n_state = S_UNLINK_A;
            end
            S_UNLINK_A: begin
                o_op    = OP_UNLINK_A;
                n_state = S_UNLINK_B;
            end
            S_UNLINK_B: begin
                o_op    = OP_UNLINK_B;
                n_state = (r_mode == MODE_RELEASE) ? S_MERGE_STEP : S_ALLOC_SET;
            end
            S_ALLOC_SET: begin
                o_op    = OP_ALLOC_SET;
                n_state = S_FILL_ALLOC;
            end
            S_FILL_ALLOC: begin
                o_op = OP_FILL_ALLOC;
                if (i_stat.cnt_last) n_state = S_SPLIT;
            end
            S_SPLIT: begin
                o_op    = OP_SPLIT;
                n_state = i_stat.split_need ? S_CARVE_SIZE : S_DONE;
            end
            S_REL_RD: begin
                o_op    = OP_REL_RD;
                n_state = S_REL_CHK;
            end
            S_REL_CHK: begin
                o_op    = OP_REL_CHK;
                n_state = i_stat.kind_head ? S_MERGE_RD : S_DONE;
            end
            S_MERGE_RD: begin
                o_op    = OP_MERGE_RD;
                n_state = i_stat.can_merge ? S_MERGE_TEST : S_REL_SET;
            end
            S_MERGE_TEST: begin
                n_state = i_stat.buddy_free ? S_UNLINK_RD : S_REL_SET;
            end
            S_MERGE_STEP: begin
                o_op    = OP_MERGE_STEP;
                n_state = S_MERGE_RD;
            end
            S_REL_SET: begin
                o_op    = OP_REL_SET;
                n_state = S_FILL_FREE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_state == S_DONE;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_state == S_IDLE)
        else $error("result strobe not followed by idle");
    a_accept_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> r_mode == $past(i_mode))
        else $error("mode not captured at accept");
    a_release_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE_STEP || r_state == S_REL_SET) |-> r_mode == MODE_RELEASE)
        else $error("merge step outside a release");
endmodule

[rtl/buddy_page_allocator.sv]
// Top level of the buddy page allocator: controller plus datapath.
// Uses bpa_pkg, bpa_ctrl and bpa_datapath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  command  | start in, busy out     | i_mode, i_order, i_first_page, i_last_page
//  result   | o_done strobe, 1 cycle | o_status, o_page, o_block_order, o_free_total
//  config   | i_cfg_we               | i_cfg_wdata (page limit)
//
// A transaction runs one page-info memory access at a time: add scans and
// then writes each page of a block and pushes the block; allocate searches
// up from the requested order, unlinks the block, marks each of its pages
// and carves the split rest; release merges level by level, then marks each
// page of the final block. A clearing pass over every page after reset holds busy
// high. Results cannot be stalled; busy stays high until the strobe cycle ends.
module buddy_page_allocator import bpa_pkg::*; #(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int ORDERS    = ORDERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [ORDER_W-1:0]  i_order,
    input  logic [PAGE_W-1:0]   i_first_page,
    input  logic [PAGE_W-1:0]   i_last_page,
    input  logic                i_cfg_we,
    input  logic [LIMIT_W-1:0]  i_cfg_wdata,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [PAGE_W-1:0]   o_page,
    output logic [ORDER_W-1:0]  o_block_order,
    output logic [TOTAL_W-1:0]  o_free_total
);
    t_dp_op   w_op;
    t_dp_stat w_stat;

    bpa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_mode(i_mode),
        .i_stat(w_stat), .o_op(w_op), .o_busy(busy), .o_done(o_done)
    );

    bpa_datapath #(.NUM_PAGES(NUM_PAGES), .ORDERS(ORDERS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(w_op), .i_order(i_order),
        .i_first_page(i_first_page), .i_last_page(i_last_page),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_stat(w_stat),
        .o_status(o_status), .o_page(o_page), .o_block_order(o_block_order),
        .o_free_total(o_free_total)
    );
endmodule

[test/tb_buddy_page_allocator.sv]
// Self-checking testbench for buddy_page_allocator: directed and random
// add / allocate / release transactions against an in-bench allocator model.
// Depends on bpa_pkg and the buddy_page_allocator RTL.
`timescale 1ns / 100ps

module tb_buddy_page_allocator;
    import bpa_pkg::*;

    localparam int NPG = 4096;
    localparam int NORD = 11;
    localparam int NIL_IDX = NPG;
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page;
        logic [ORDER_W-1:0]  bord;
        logic [TOTAL_W-1:0]  total;
    } t_alloc_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [MODE_W-1:0] i_mode = '0;
    logic [ORDER_W-1:0] i_order = '0;
    logic [PAGE_W-1:0] i_first_page = '0;
    logic [PAGE_W-1:0] i_last_page = '0;
    logic i_cfg_we = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wdata = '0;
    logic o_done;
    logic [STATUS_W-1:0] o_status;
    logic [PAGE_W-1:0] o_page;
    logic [ORDER_W-1:0] o_block_order;
    logic [TOTAL_W-1:0] o_free_total;

    buddy_page_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_order(i_order), .i_first_page(i_first_page),
        .i_last_page(i_last_page), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_done(o_done), .o_status(o_status), .o_page(o_page),
        .o_block_order(o_block_order), .o_free_total(o_free_total)
    );

    // allocator shadow state
    logic [1:0]         pg_kind [NPG];
    logic [ORDER_W-1:0] pg_ord  [NPG];
    logic [12:0]        pg_next [NPG];
    logic [12:0]        pg_prev [NPG];
    logic [12:0]        ord_head [NORD];
    logic [TOTAL_W-1:0] free_cnt;
    logic [LIMIT_W-1:0] limit_reg;

    t_alloc_res pending_res[$];
    int live_heads[$];
    int errors = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    bit accepted_now;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void list_push(int p, int o);
        int h;
        h = ord_head[o];
        pg_next[p] = 13'(h);
        pg_prev[p] = 13'(NIL_IDX);
        if (h < NIL_IDX) pg_prev[h] = 13'(p);
        ord_head[o] = 13'(p);
    endfunction

    function automatic void list_unlink(int p, int o);
        int n, v;
        n = pg_next[p];
        v = pg_prev[p];
        if (v < NIL_IDX) pg_next[v] = 13'(n);
        else ord_head[o] = 13'(n);
        if (n < NIL_IDX) pg_prev[n] = 13'(v);
        pg_next[p] = 13'(NIL_IDX);
        pg_prev[p] = 13'(NIL_IDX);
    endfunction

    function automatic void free_block(int p, int o);
        for (int k = 0; k < (1 << o); k++) begin
            pg_kind[p + k] = KIND_FREE;
            pg_ord[p + k] = ORDER_W'(o);
        end
        list_push(p, o);
        free_cnt += TOTAL_W'(1 << o);
    endfunction

    function automatic void carve_range(int s, int e, bit chk);
        int o;
        bit clean;
        while (s <= e) begin
            o = 0;
            while (o < NORD - 1 && ((s >> o) & 1) == 0) o++;
            while (e - s + 1 < (1 << o)) o--;
            clean = 1'b1;
            if (chk)
                for (int k = 0; k < (1 << o); k++)
                    if (pg_kind[s + k] != KIND_UNUSED) clean = 1'b0;
            if (clean) free_block(s, o);
            s += (1 << o);
        end
    endfunction

    function automatic t_alloc_res alloc_predict(logic [MODE_W-1:0] mode, int req,
                                                 int first, int last);
        t_alloc_res r;
        int i, p, o, b;
        r.status = ST_OK;
        r.page = '0;
        r.bord = '0;
        if (mode == MODE_ADD) begin
            if (first <= last) carve_range(first, last, 1'b1);
        end else if (mode == MODE_ALLOC) begin
            if (req >= NORD) begin
                r.status = ST_BAD_ORDER;
            end else begin
                i = req;
                while (i < NORD && ord_head[i] >= NIL_IDX) i++;
                if (i >= NORD) begin
                    r.status = ST_NO_BLOCK;
                end else begin
                    p = ord_head[i];
                    list_unlink(p, i);
                    free_cnt -= TOTAL_W'(1 << i);
                    for (int k = 0; k < (1 << req); k++) begin
                        pg_kind[p + k] = (k != 0) ? KIND_ELEM : KIND_HEAD;
                        pg_ord[p + k] = ORDER_W'(req);
                    end
                    if (i > req) carve_range(p + (1 << req), p + (1 << i) - 1, 1'b0);
                    r.page = PAGE_W'(p);
                    r.bord = ORDER_W'(req);
                    live_heads.push_back(p);
                end
            end
        end else if (mode == MODE_RELEASE) begin
            if (pg_kind[first] != KIND_HEAD) begin
                r.status = ST_BAD_PAGE;
            end else begin
                p = first;
                o = pg_ord[p];
                if (o >= NORD) o = NORD - 1;
                pg_kind[p] = KIND_FREE;
                foreach (live_heads[j])
                    if (live_heads[j] == first) begin
                        live_heads.delete(j);
                        break;
                    end
                while (o + 1 < NORD) begin
                    b = p ^ (1 << o);
                    if (b >= limit_reg || b >= NPG) break;
                    if (pg_kind[b] != KIND_FREE || pg_ord[b] != o) break;
                    list_unlink(b, o);
                    free_cnt -= TOTAL_W'(1 << o);
                    if (b < p) p = b;
                    o++;
                end
                free_block(p, o);
                r.page = PAGE_W'(p);
                r.bord = ORDER_W'(o);
            end
        end
        r.total = free_cnt;
        return r;
    endfunction

    // one command transaction; leaves start high after acceptance
    task automatic send_cmd(logic [MODE_W-1:0] mode, logic [ORDER_W-1:0] ord,
                            logic [PAGE_W-1:0] first, logic [PAGE_W-1:0] last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= mode;
        i_order <= ord;
        i_first_page <= first;
        i_last_page <= last;
        do @(posedge i_clk); while (busy);
        pending_res.push_back(alloc_predict(mode, ord, first, last));
    endtask

    // wait for the block to go idle, then write the page limit
    task automatic write_limit(logic [LIMIT_W-1:0] v);
        start <= 1'b0;
        while (pending_res.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        limit_reg = v;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        send_cmd(MODE_NOP, 4'd0, 12'd0, 12'd0);
        send_cmd(MODE_ALLOC, 4'd0, 12'd0, 12'd0);      // nothing donated yet
        send_cmd(MODE_ALLOC, 4'd11, 12'd0, 12'd0);
        send_cmd(MODE_ALLOC, 4'd15, 12'd0, 12'd0);
        send_cmd(MODE_RELEASE, 4'd0, 12'd4095, 12'd0);
        send_cmd(MODE_ADD, 4'd0, 12'd9, 12'd3);         // empty range
        send_cmd(MODE_ADD, 4'd0, 12'd0, 12'd0);
        send_cmd(MODE_ADD, 4'd0, 12'd1, 12'd2047);
        send_cmd(MODE_ADD, 4'd0, 12'd4095, 12'd4095);
        send_cmd(MODE_ADD, 4'd0, 12'd100, 12'd300);      // overlaps donated pages
        send_cmd(MODE_ALLOC, 4'd10, 12'd0, 12'd0);
        send_cmd(MODE_ALLOC, 4'd0, 12'd0, 12'd0);
        send_cmd(MODE_ALLOC, 4'd3, 12'd0, 12'd0);
        send_cmd(MODE_ALLOC, 4'd10, 12'd0, 12'd0);
        send_cmd(MODE_ALLOC, 4'd10, 12'd0, 12'd0);       // likely none left
        send_cmd(MODE_RELEASE, 4'd0, 12'd1, 12'd0);      // free page, not head
        while (live_heads.size() != 0)
            send_cmd(MODE_RELEASE, 4'd0, PAGE_W'(live_heads[0]), 12'd0);
        send_cmd(MODE_RELEASE, 4'd0, 12'd0, 12'd0);      // release of a free page
        send_cmd(MODE_NOP, 4'd15, 12'hFFF, 12'hFFF);
    endtask

    task automatic test_random(int n);
        int sel, a, len;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 18) begin
                a = $urandom_range(0, NPG - 1);
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, NPG - 1)
                                                   : $urandom_range(0, 40);
                if ($urandom_range(0, 9) == 0)
                    send_cmd(MODE_ADD, ORDER_W'($urandom), PAGE_W'($urandom),
                             PAGE_W'($urandom));
                else
                    send_cmd(MODE_ADD, ORDER_W'($urandom), PAGE_W'(a),
                             PAGE_W'((a + len > NPG - 1) ? NPG - 1 : a + len));
            end else if (sel < 58) begin
                send_cmd(MODE_ALLOC,
                         ORDER_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                              : $urandom_range(0, 4)),
                         PAGE_W'($urandom), PAGE_W'($urandom));
            end else if (sel < 95) begin
                if (live_heads.size() != 0 && $urandom_range(0, 9) != 0)
                    send_cmd(MODE_RELEASE, ORDER_W'($urandom),
                             PAGE_W'(live_heads[$urandom_range(0, live_heads.size() - 1)]),
                             PAGE_W'($urandom));
                else
                    send_cmd(MODE_RELEASE, ORDER_W'($urandom), PAGE_W'($urandom),
                             PAGE_W'($urandom));
            end else begin
                send_cmd(MODE_NOP, ORDER_W'($urandom), PAGE_W'($urandom),
                         PAGE_W'($urandom));
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_alloc_res e;
        accepted_now = start && !busy && i_rst_n;
        if (o_done && i_rst_n) begin
            if (pending_res.size() == 0) begin
                $display("%0t: result with none expected, got st=%0d pg=%0d ord=%0d tot=%0d",
                         $time, o_status, o_page, o_block_order, o_free_total);
                errors++;
            end else begin
                e = pending_res.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, o_status);
                    errors++;
                end
                if (o_page !== e.page) begin
                    $display("%0t: page exp %0d got %0d", $time, e.page, o_page);
                    errors++;
                end
                if (o_block_order !== e.bord) begin
                    $display("%0t: order exp %0d got %0d", $time, e.bord, o_block_order);
                    errors++;
                end
                if (o_free_total !== e.total) begin
                    $display("%0t: free total exp %0d got %0d", $time, e.total, o_free_total);
                    errors++;
                end
            end
        end
        // watchdog: cycles with no transaction in either direction
        if (accepted_now || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_buddy_page_allocator: done, errors");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NPG; i++) begin
            pg_kind[i] = KIND_UNUSED;
            pg_ord[i] = '0;
            pg_next[i] = 13'(NIL_IDX);
            pg_prev[i] = 13'(NIL_IDX);
        end
        for (int o = 0; o < NORD; o++) ord_head[o] = 13'(NIL_IDX);
        free_cnt = '0;
        limit_reg = LIMIT_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_limit(13'd4096);
        test_directed();
        write_limit(13'd1);               // merging only with page 0 as buddy
        test_random(120);
        write_limit(13'd2048);
        test_random(140);
        write_limit(13'd0);
        test_random(80);
        write_limit(13'd8191);
        test_random(140);
        write_limit(LIMIT_W'($urandom_range(1, 4096)));
        test_random(140);
        write_limit(13'd4096);
        quiet = 1'b1;
        test_random(200);

        start <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("tb_buddy_page_allocator: done, clean");
        else
            $display("tb_buddy_page_allocator: done, errors");
        $finish;
    end

endmodule
